// ===== rtl/window_fifo_median_filter_defines.svh =====
// Assertion helpers for the windowed FIFO median filter.
`ifndef WINDOW_FIFO_MEDIAN_FILTER_DEFINES_SVH
`define WINDOW_FIFO_MEDIAN_FILTER_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define WFMF_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define WFMF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/wfmf_pkg.sv =====
`timescale 1ns / 1ps

package wfmf_pkg;

   localparam int DEPTH      = 16;
   localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W      = IDX_W + 1;
   localparam int SAMPLE_W   = 16;
   localparam int REQ_DATA_W = ((SAMPLE_W + 7) / 8) * 8;
   localparam int RSP_BITS   = 2 * SAMPLE_W + CNT_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_BITS;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [IDX_W-1:0]           age_type;
   typedef logic [CNT_W-1:0]           cnt_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_CALC = 2'b10
   } state_type;

   // command broadcast to every cell
   typedef struct packed {
      logic       push;
      logic       pop;
      sample_type sample;
      age_type    new_age;
   } ctrl_type;

   // what a cell shows its neighbors and the top level
   typedef struct packed {
      logic       valid;
      age_type    age;
      sample_type val;
      logic       gt;    // empty or holds a value above the pushed sample
      logic       cut;   // oldest entry sits at or below this cell
      logic       head;  // this cell holds the oldest entry
   } link_type;

endpackage

// ===== rtl/window_fifo_median_filter.sv =====
// Channel | Dir | Transfer fields
// req     | in  | tuser[0] operation; tdata[15:0] sample
// rsp     | out | tuser[0] done_res, [1] median_valid; tdata popped, occupancy, median
//
// The cell row updates at the req transfer; the median is then picked from the sorted
// row and summed into the rsp register, and no req is taken while that is pending.
// A new req transfer is taken while a rsp still waits; the median step then
// holds until the rsp register frees up.
// Synchronous reset empties the FIFO; no clearing pass is needed.
`timescale 1ns / 1ps
`include "window_fifo_median_filter_defines.svh"

module window_fifo_median_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [wfmf_pkg::REQ_DATA_W-1:0]     req_tdata,  // [15:0] sample
   input  logic                                req_tuser,  // [0] operation
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [wfmf_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // popped, occupancy, median, pad
   output logic [1:0]                          rsp_tuser   // [0] done_res, [1] median_valid
);

   localparam int DEPTH = wfmf_pkg::DEPTH;
   localparam int IW    = wfmf_pkg::IDX_W;
   localparam int CW    = wfmf_pkg::CNT_W;
   localparam int SW    = wfmf_pkg::SAMPLE_W;

   wfmf_pkg::state_type  state_ff, state_in;
   wfmf_pkg::cnt_type    count_ff, count_in;
   logic                 done_ff;
   wfmf_pkg::sample_type popped_ff;
   logic                 rsp_tvalid_ff;
   logic [wfmf_pkg::RSP_DATA_W-1:0] rsp_tdata_ff;
   logic [1:0]           rsp_tuser_ff;

   wfmf_pkg::ctrl_type   ctrl;
   wfmf_pkg::link_type   cell_out [DEPTH];
   wfmf_pkg::link_type   tie;
   wfmf_pkg::sample_type cell_val [DEPTH];
   logic [DEPTH-1:0]     valid_vec, head_vec;
   wfmf_pkg::sample_type popped_sel, median;
   logic                 req_xfer, is_pop, push_ok, pop_ok, out_free;

   assign tie = '{valid: 1'b0, age: '0, val: '0, gt: 1'b0, cut: 1'b0, head: 1'b0};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      wfmf_pkg::link_type lo, hi;
      if (i == 0) begin : g_first
         assign lo = tie;
      end else begin : g_mid
         assign lo = cell_out[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign hi = tie;
      end else begin : g_inner
         assign hi = cell_out[i+1];
      end
      wfmf_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctrl  (ctrl),
         .lo    (lo),
         .hi    (hi),
         .link  (cell_out[i])
      );
      assign cell_val[i]  = cell_out[i].val;
      assign valid_vec[i] = cell_out[i].valid;
      assign head_vec[i]  = cell_out[i].head;
   end

   wfmf_median u_median (
      .vals   (cell_val),
      .count  (count_ff),
      .median (median)
   );

   assign req_tready = (state_ff == wfmf_pkg::ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      is_pop       = (req_tuser == wfmf_pkg::OP_POP);
      push_ok      = !is_pop && (count_ff != CW'(DEPTH));
      pop_ok       = is_pop && (count_ff != '0);
      ctrl.push    = req_xfer && push_ok;
      ctrl.pop     = req_xfer && pop_ok;
      ctrl.sample  = req_tdata[SW-1:0];
      ctrl.new_age = count_ff[IW-1:0];
      popped_sel   = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (head_vec[i]) begin
            popped_sel = popped_sel | cell_val[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop) begin
         count_in = count_ff - 1'b1;
      end
      state_in = state_ff;
      case (state_ff)
         wfmf_pkg::ST_IDLE: begin
            if (req_xfer) begin
               state_in = wfmf_pkg::ST_CALC;
            end
         end
         wfmf_pkg::ST_CALC: begin
            if (out_free) begin
               state_in = wfmf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wfmf_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= wfmf_pkg::ST_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == wfmf_pkg::ST_CALC && out_free) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         done_ff   <= push_ok || pop_ok;
         popped_ff <= pop_ok ? popped_sel : '0;
      end
      if (state_ff == wfmf_pkg::ST_CALC && out_free) begin
         rsp_tdata_ff <= {{wfmf_pkg::RSP_PAD_W{1'b0}}, median, count_ff, popped_ff};
         rsp_tuser_ff <= {count_ff != '0, done_ff};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   `WFMF_ASSERT_ALWAYS(a_count_range, count_ff <= CW'(DEPTH), "occupancy above depth")
   `WFMF_ASSERT_ALWAYS(a_cells_match_count, $countones(valid_vec) == count_ff, "cell row out of step with occupancy")
   `WFMF_ASSERT_ALWAYS(a_one_head, $onehot0(head_vec) && ((count_ff == '0) || $onehot(head_vec)), "oldest entry not unique")
   `WFMF_ASSERT_NEXT(a_pop_count, ctrl.pop, count_ff == $past(count_ff) - 1'b1, "pop did not lower occupancy")

endmodule

// ===== rtl/wfmf_cell.sv =====
`timescale 1ns / 1ps

module wfmf_cell (
   input  logic               clock,
   input  logic               reset,
   input  wfmf_pkg::ctrl_type ctrl,
   input  wfmf_pkg::link_type lo,
   input  wfmf_pkg::link_type hi,
   output wfmf_pkg::link_type link
);

   logic                 valid_ff, valid_in;
   wfmf_pkg::age_type    age_ff, age_in;
   wfmf_pkg::sample_type val_ff, val_in;
   logic                 gt, head, cut;

   always_comb begin
      gt   = !valid_ff || (val_ff > ctrl.sample);
      head = valid_ff && (age_ff == '0);
      cut  = head || lo.cut;
      link = '{valid: valid_ff, age: age_ff, val: val_ff, gt: gt, cut: cut, head: head};
   end

   always_comb begin
      valid_in = valid_ff;
      age_in   = age_ff;
      val_in   = val_ff;
      if (ctrl.push && gt) begin
         if (lo.gt) begin
            valid_in = lo.valid;
            age_in   = lo.age;
            val_in   = lo.val;
         end else begin
            valid_in = 1'b1;
            age_in   = ctrl.new_age;
            val_in   = ctrl.sample;
         end
      end else if (ctrl.pop) begin
         if (cut) begin
            valid_in = hi.valid;
            age_in   = hi.age - 1'b1;
            val_in   = hi.val;
         end else begin
            age_in   = age_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      age_ff <= age_in;
      val_ff <= val_in;
   end

endmodule

// ===== rtl/wfmf_median.sv =====
`timescale 1ns / 1ps

module wfmf_median (
   input  wfmf_pkg::sample_type vals [wfmf_pkg::DEPTH],
   input  wfmf_pkg::cnt_type    count,
   output wfmf_pkg::sample_type median
);

   localparam int IW = wfmf_pkg::IDX_W;
   localparam int SW = wfmf_pkg::SAMPLE_W;

   wfmf_pkg::cnt_type    cnt_m1;
   logic [IW-1:0]        lo_idx, hi_idx;
   wfmf_pkg::sample_type lo_val, hi_val;
   logic [SW:0]          sum;

   always_comb begin
      cnt_m1 = count - 1'b1;
      lo_idx = cnt_m1[IW:1];
      hi_idx = count[IW:1];
      lo_val = '0;
      hi_val = '0;
      for (int i = 0; i < wfmf_pkg::DEPTH; i++) begin
         if (lo_idx == IW'(i)) begin
            lo_val = lo_val | vals[i];
         end
         if (hi_idx == IW'(i)) begin
            hi_val = hi_val | vals[i];
         end
      end
      // floor of the mean; equal middles for an odd count
      sum    = {lo_val[SW-1], lo_val} + {hi_val[SW-1], hi_val};
      median = (count == '0) ? '0 : sum[SW:1];
   end

endmodule
